FILE: rtl/bfs_pkg.sv
// package: shared types, constants and tables for the box filter sum block
`timescale 1ns / 1ps
package bfs_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 7;

  // fixed field widths
  localparam int MAX_HEIGHT  = 4096;
  localparam int ROW_W       = 13;
  localparam int CMD_COL_W   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;

  // reciprocal scaling for the row modulo
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2
  } cfg_reg_t;

  // input beat
  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [15:0] box_sum;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_in_run;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0]           pixel;
    logic [ROW_W-1:0]     row;
    logic [CMD_COL_W-1:0] col;
    logic [2:0]           radius;
    logic                 last_col;
  } cmd_t;

  // ceil(2^18 / (2r)) for the line slot modulo
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      3'd1:    m = 18'd131072;
      3'd2:    m = 18'd65536;
      3'd3:    m = 18'd43691;
      3'd4:    m = 18'd32768;
      3'd5:    m = 18'd26215;
      3'd6:    m = 18'd21846;
      3'd7:    m = 18'd18725;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/bfs_fifo.sv
// module: small register queue used between front and back and on the result side
`timescale 1ns / 1ps
module bfs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  // handshake and pointer update
  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("queue count out of range");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && !empty)) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on a lone push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !(push && !full)) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not shrink on a lone pop");

endmodule

FILE: rtl/bfs_front.sv
// module: front end, tracks raster position and classifies each input beat
`timescale 1ns / 1ps
module bfs_front #(
  parameter int MAX_WIDTH = bfs_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  bfs_pkg::in_item_t                in_data,
  output logic                             in_full,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_eff,
  input  logic [bfs_pkg::ROW_W-1:0]        h_eff,
  input  logic [2:0]                       r_eff,
  input  logic                             clearing,
  output logic                             cmd_push,
  output bfs_pkg::cmd_t                    cmd_data,
  input  logic                             cmd_full
);
  import bfs_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = WW + 1;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row0, y;
  logic [CW-1:0]    col0, x;
  logic [CMP_W-1:0] x_inc;
  logic             accept, wrap, done, eol, below;

  assign in_full = cmd_full || clearing;

  // position and classification
  always_comb begin
    accept = in_push && !in_full;
    row0   = in_data.frame_start ? '0 : row_r;
    col0   = in_data.frame_start ? '0 : col_r;
    wrap   = CMP_W'(col0) >= CMP_W'(w_eff);
    y      = wrap ? row0 + 1'b1 : row0;
    x      = wrap ? '0 : col0;
    done   = (ROW_W + 1)'(y) >= ((ROW_W + 1)'(h_eff) + (ROW_W + 1)'(r_eff));
    below  = y >= h_eff;
    x_inc  = CMP_W'(x) + 1'b1;
    eol    = x_inc >= CMP_W'(w_eff);

    cmd_data.pixel    = (!in_data.action && !below) ? in_data.pixel : 8'd0;
    cmd_data.row      = y;
    cmd_data.col      = CMD_COL_W'(x);
    cmd_data.radius   = r_eff;
    cmd_data.last_col = eol;
    cmd_push          = accept && !done;

    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (done) begin
        row_nxt = y;
        col_nxt = x;
      end else if (eol) begin
        row_nxt = y + 1'b1;
        col_nxt = '0;
      end else begin
        row_nxt = y;
        col_nxt = CW'(x_inc);
      end
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

FILE: rtl/bfs_back.sv
// module: back end, line store, column sums, window and result sequencing
`timescale 1ns / 1ps
module bfs_back #(
  parameter int MAX_WIDTH  = bfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bfs_pkg::DEF_MAX_RADIUS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  bfs_pkg::cmd_t      cmd_data,
  output logic               cmd_pop,
  output logic               res_push,
  output bfs_pkg::out_item_t res_data,
  input  logic               res_full,
  output logic               clearing
);
  import bfs_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int LINE_ROWS  = 2 * MAX_RADIUS;
  localparam int WIN_LEN    = 2 * MAX_RADIUS + 1;
  localparam int IW         = $clog2(WIN_LEN);
  localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;
  localparam int LAW        = $clog2(LINE_DEPTH);
  localparam int SW         = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int PW         = ROW_W + RECIP_W;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_MOD  = 7'b0001000,
    ST_RD   = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r;
  logic [11:0]   q_r;
  logic [SW-1:0] slot_r;
  logic [11:0]   cs_rd_r;
  logic [7:0]    pl_rd_r;
  logic [15:0]   rs_r;
  logic [15:0]   s_r;
  logic [11:0]   win_r [WIN_LEN];
  logic [2:0]    k_r, kmax_r;
  logic [CW-1:0] clr_r;

  logic [11:0]   colmem [MAX_WIDTH];
  logic [7:0]    linemem [LINE_DEPTH];

  logic [3:0]     d;
  logic [PW-1:0]  prod;
  logic [15:0]    qd, rem, rem_c;
  logic [CW-1:0]  x_idx;
  logic [LAW-1:0] line_addr;
  logic [IW-1:0]  wi;
  logic [11:0]    tail, tail_base, old, v, sub, cs_new;
  logic [15:0]    rs_base, rs_new;
  logic           emit_ok, emit_adv, is_last;

  // datapath terms
  always_comb begin
    d         = {cmd_r.radius, 1'b0};
    prod      = PW'(cmd_r.row) * PW'(recip(cmd_r.radius));
    qd        = 16'(q_r) * 16'(d);
    rem       = 16'(cmd_r.row) - qd;
    rem_c     = (rem >= 16'(d)) ? rem - 16'(d) : rem;
    x_idx     = cmd_r.col[CW-1:0];
    line_addr = LAW'(32'(slot_r) * MAX_WIDTH + 32'(x_idx));
    wi        = IW'(2 * 32'(cmd_r.radius));
    tail      = win_r[wi];
    tail_base = (cmd_r.col == '0) ? 12'd0 : tail;
    rs_base   = (cmd_r.col == '0) ? 16'd0 : rs_r;
    old       = (cmd_r.row == '0) ? 12'd0 : cs_rd_r;
    v         = old + 12'(cmd_r.pixel);
    sub       = ((ROW_W + 1)'(cmd_r.row) >= (ROW_W + 1)'(d)) ? 12'(pl_rd_r) : 12'd0;
    cs_new    = (cmd_r.radius == '0) ? 12'd0 : v - sub;
    rs_new    = rs_base + 16'(v) - 16'(tail_base);
    emit_ok   = (14'(cmd_r.col) + 14'(k_r)) >= 14'(cmd_r.radius);
    is_last   = (k_r == kmax_r);
    emit_adv  = (state_r == ST_EMIT) && (!emit_ok || !res_full);
  end

  // result beat
  always_comb begin
    res_push             = (state_r == ST_EMIT) && emit_ok && !res_full;
    res_data.box_sum     = s_r;
    res_data.out_row     = 12'(cmd_r.row - ROW_W'(cmd_r.radius));
    res_data.out_col     = 10'(14'(cmd_r.col) + 14'(k_r) - 14'(cmd_r.radius));
    res_data.last_in_run = is_last;
  end

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign clearing = (state_r == ST_CLR);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_r == CW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (!cmd_empty) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (cmd_r.row >= ROW_W'(cmd_r.radius)) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (emit_adv && is_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      rs_r    <= '0;
      k_r     <= '0;
      kmax_r  <= '0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_UPD) begin
        rs_r   <= rs_new;
        k_r    <= '0;
        kmax_r <= cmd_r.last_col ? cmd_r.radius : 3'd0;
        for (int i = 0; i < WIN_LEN; i++) begin
          if (i == 0) begin
            win_r[i] <= v;
          end else begin
            win_r[i] <= (cmd_r.col == '0) ? 12'd0 : win_r[i-1];
          end
        end
      end
      // right edge run: drop the oldest column each step
      if (emit_adv && !is_last) begin
        k_r <= k_r + 1'b1;
        for (int i = 0; i < WIN_LEN; i++) begin
          win_r[i] <= (i == 0) ? 12'd0 : win_r[i-1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_data;
    end
    if (state_r == ST_DIV) begin
      q_r <= 12'(prod >> RECIP_SHIFT);
    end
    if (state_r == ST_MOD) begin
      slot_r <= SW'(rem_c);
    end
    if (state_r == ST_UPD) begin
      s_r <= rs_new;
    end else if (emit_adv && !is_last) begin
      s_r <= s_r - 16'(tail);
    end
  end

  // column sum memory
  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) begin
      colmem[clr_r] <= '0;
    end else if (state_r == ST_UPD) begin
      colmem[x_idx] <= cs_new;
    end
    if (state_r == ST_RD) begin
      cs_rd_r <= colmem[x_idx];
    end
  end

  // pixel line memory
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && cmd_r.radius != '0) begin
      linemem[line_addr] <= cmd_r.pixel;
    end
    if (state_r == ST_RD) begin
      pl_rd_r <= linemem[line_addr];
    end
  end

endmodule

FILE: rtl/box_filter_sum_2d_core.sv
// top level: box filter window sum over a raster pixel stream
//
//  channel  ports                          beat
//  in       in_push / in_full / in_data    one pixel or drain tick
//  out      out_pop / out_empty / out_data one window sum with its position
//  cfg      cfg_valid / cfg_ready          register index and write data
//
// each item passes the back end steps pop, modulo, slot, memory read, update
// and emit, skipping emit when its row is above the first output row; the last
// column of a row adds an emit step for each radius step of the right edge run,
// with the single result write per cycle while the result queue is not full
// after reset a clearing pass over all MAX_WIDTH entries zeroes the column sums,
// with in_full high throughout; configuration writes are taken at once
// a full result queue stalls the back end, and a full command queue in_full
`timescale 1ns / 1ps
module box_filter_sum_2d_core #(
  parameter int MAX_WIDTH  = bfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bfs_pkg::DEF_MAX_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  bfs_pkg::in_item_t                in_data,
  output logic                             in_full,
  output logic                             out_empty,
  input  logic                             out_pop,
  output bfs_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bfs_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [10:0]      width_r;
  logic [12:0]      height_r;
  logic [2:0]       radius_r;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [2:0]       r_eff;

  logic      cmd_push, cmd_full, cmd_empty, cmd_pop, clearing;
  cmd_t      cmd_in, cmd_out;
  logic      res_push, res_full;
  out_item_t res_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      radius_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data[12:0];
        CFG_WINDOW_RADIUS: radius_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamped working values
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    r_eff = (32'(radius_r) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_r;
  end

  bfs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .r_eff    (r_eff),
    .clearing (clearing),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  bfs_fifo #(.W($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  bfs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .clearing  (clearing)
  );

  bfs_fifo #(.W($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

FILE: dv/testbench.sv
// testbench: random and directed frame streams checked against a window sum predictor
`timescale 1ns / 1ps
module testbench;
  import bfs_pkg::*;

  // scoreboard: predicts window sums from accepted beats and checks result beats
  class box_sum_board;
    int unsigned width_reg = 640;
    int unsigned height_reg = 480;
    int unsigned radius_reg = 1;
    byte unsigned line_store [14336];
    int unsigned col_sums [1024];
    int unsigned win_cols [15];
    int unsigned run_sum;
    int unsigned row_pos;
    int unsigned col_pos;
    out_item_t pending_sums [$];
    int mismatches;

    function void set_reg(cfg_reg_t idx, int unsigned value);
      case (idx)
        CFG_IMAGE_WIDTH:   width_reg = value & 'h7ff;
        CFG_IMAGE_HEIGHT:  height_reg = value & 'h1fff;
        CFG_WINDOW_RADIUS: radius_reg = value & 'h7;
        default: ;
      endcase
    endfunction

    function void note_pixel(in_item_t it);
      int unsigned w, h, r, len, y, x, p, v, old, sub, slot, s, k;
      out_item_t runs [$];
      out_item_t res;
      w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > 4096) ? 4096 : height_reg;
      r = radius_reg;
      len = 2 * r + 1;
      if (it.frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 'h1fff;
      end
      y = row_pos;
      x = col_pos;
      if (y >= h + r) return;
      p = (!it.action && y < h) ? it.pixel : 0;
      // vertical column sum over the last 2r+1 rows
      old = (y == 0) ? 0 : col_sums[x];
      v = (old + p) & 'hfff;
      if (r == 0) begin
        col_sums[x] = 0;
      end else begin
        slot = y % (2 * r);
        sub = (y >= 2 * r) ? line_store[slot * 1024 + x] : 0;
        col_sums[x] = (v - sub) & 'hfff;
        line_store[slot * 1024 + x] = p;
      end
      // horizontal running sum, newest column first
      if (x == 0) begin
        foreach (win_cols[i]) win_cols[i] = 0;
        run_sum = 0;
      end
      run_sum = (run_sum + v - win_cols[len - 1]) & 'hffff;
      for (int i = 14; i > 0; i--) win_cols[i] = win_cols[i - 1];
      win_cols[0] = v;
      if (y >= r) begin
        s = run_sum;
        res.out_row = y - r;
        res.last_in_run = 1'b0;
        if (x >= r) begin
          res.box_sum = s;
          res.out_col = x - r;
          runs.push_back(res);
        end
        // right edge run at the end of the row
        if (x == w - 1) begin
          for (k = 1; k <= r; k++) begin
            s = (s - win_cols[len - k]) & 'hffff;
            if (x + k >= r) begin
              res.box_sum = s;
              res.out_col = x + k - r;
              runs.push_back(res);
            end
          end
        end
        if (runs.size() > 0) runs[runs.size() - 1].last_in_run = 1'b1;
        foreach (runs[i]) pending_sums.push_back(runs[i]);
      end
      col_pos = x + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (y + 1) & 'h1fff;
      end
    endfunction

    function void check_sum(out_item_t got);
      out_item_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected sum %0d row %0d col %0d last %0b,",
                   want.box_sum, want.out_row, want.out_col, want.last_in_run,
                   " got sum %0d row %0d col %0d last %0b",
                   got.box_sum, got.out_row, got.out_col, got.last_in_run);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_sum_board board = new();
  int pixels_sent;
  int quiet;
  int idle_cycles;
  int stall_left;
  bit long_hold_done;
  bit hold_now;

  box_filter_sum_2d_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check beats, random pop stalls, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_sum(out_data);
    if (stall_left > 0) begin
      out_pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_hold_done && hold_now) begin
      long_hold_done <= 1'b1;
      out_pop <= 1'b0;
      stall_left <= 500;
    end else begin
      int roll;
      roll = $urandom_range(99);
      if (quiet || roll < 65) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b0;
        stall_left <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_pixel(input logic action, input logic [7:0] pixel, input logic fs);
    int gap;
    int roll;
    roll = $urandom_range(99);
    gap = (quiet || roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{action: action, pixel: pixel, frame_start: fs};
    do @(posedge clk); while (in_full);
    board.note_pixel('{action: action, pixel: pixel, frame_start: fs});
    pixels_sent++;
  endtask

  // wait until every expected beat is out, then let the pipeline settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (board.pending_sums.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned r);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_WINDOW_RADIUS, r);
  endtask

  // one frame of random pixels, drain ticks, and a few ignored beats after
  task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned r,
                           input bit noisy);
    int unsigned ew, eh, total;
    ew = (w == 0) ? 1 : (w > 1024) ? 1024 : w;
    eh = (h == 0) ? 1 : (h > 4096) ? 4096 : h;
    total = ew * eh;
    for (int unsigned i = 0; i < total; i++)
      send_pixel(1'b0, $urandom_range(255), i == 0 || (noisy && $urandom_range(99) < 3));
    for (int unsigned i = 0; i < ew * r; i++)
      send_pixel($urandom_range(99) < 80, $urandom_range(255), 1'b0);
    repeat ($urandom_range(0, 2)) send_pixel($urandom_range(1), $urandom_range(255), 1'b0);
  endtask

  initial begin
    int unsigned w, h, r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pixel extremes, drain and pixels below frame, ignored beats
    set_frame(4, 2, 1);
    send_pixel(1'b0, 8'd255, 1'b1);
    send_pixel(1'b0, 8'd0, 1'b0);
    send_pixel(1'b0, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd170, 1'b0);
    repeat (4) send_pixel(1'b0, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd85, 1'b0);
    send_pixel(1'b1, 8'd0, 1'b0);
    send_pixel(1'b0, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd255, 1'b0);

    // directed: width lowered part way through a row
    set_frame(5, 3, 1);
    for (int i = 0; i < 13; i++) send_pixel(1'b0, $urandom_range(255), i == 0);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 2);
    repeat (6) send_pixel(1'b0, $urandom_range(255), 1'b0);

    // directed: zero sizes and radius zero
    set_frame(0, 0, 0);
    run_frame(0, 0, 0, 1'b0);

    // random frames
    while (pixels_sent < 90) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      h = $urandom_range(0, 6);
      r = $urandom_range(0, 7);
      quiet = ($urandom_range(3) == 0);
      set_frame(w, h, r);
      run_frame(w, h, r, 1'b1);
    end
    quiet = 0;

    // extremes: start of the widest and tallest frames, long result hold-off
    set_frame(11'h7ff, 1, 0);
    hold_now = 1'b1;
    for (int i = 0; i < 30; i++) send_pixel(1'b0, $urandom_range(255), i == 0);
    set_frame(1, 13'h1fff, 7);
    for (int i = 0; i < 30; i++) send_pixel(1'b0, $urandom_range(255), i == 0);
    set_frame(12, 2, 7);
    run_frame(12, 2, 7, 1'b0);

    wait_idle();
    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.pending_sums.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
